// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the stack pop checker.
// Each macro expects signals clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/spsc_pkg.sv -----
// Package of the stack pop sequence checker.
// Field widths, defaults and the command/status structs between controller and datapath.
package spsc_pkg;

	localparam int VAL_W          = 13;
	localparam int MAX_VALUES_DEF = 4096;
	localparam logic [VAL_W-1:0] BALL_COUNT_RST = 13'd4096;

	typedef struct packed {
		logic load_in;
		logic set_fail;
		logic set_high;
		logic load_k;
		logic push;
		logic pop;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic latch;
		logic bad;
		logic above;
		logic need_push;
		logic empty;
		logic push_last;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/spsc_if.sv -----
// Valid/ready channel interfaces of the stack pop sequence checker.
// Depends on spsc_pkg for the field width.
interface spsc_in_if;
	import spsc_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface spsc_out_if;
	logic valid;
	logic ready;
	logic failed;
	logic sequence_done;
	modport source (output valid, output failed, output sequence_done, input ready);
	modport sink (input valid, input failed, input sequence_done, output ready);
endinterface

// ----- rtl/spsc_ctrl.sv -----
// Controller of the stack pop sequence checker: one-hot state machine.
// Depends on spsc_pkg; drives commands to spsc_dp from its status.
module spsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spsc_pkg::stat_t stat,
	output spsc_pkg::cmd_t  cmd
);
	import spsc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_PUSH = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_FIN;
				if (stat.latch) begin
					state_d = ST_FIN;
				end else if (stat.bad) begin
					cmd.set_fail = 1'b1;
				end else if (stat.above) begin
					if (stat.need_push) begin
						cmd.load_k = 1'b1;
						state_d    = ST_PUSH;
					end else begin
						cmd.set_high = 1'b1;
					end
				end else if (stat.empty) begin
					cmd.set_fail = 1'b1;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				if (stat.push_last) begin
					cmd.set_high = 1'b1;
					state_d      = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/spsc_dp.sv -----
// Datapath of the stack pop sequence checker: stack memory, sequence state, result register.
// Depends on spsc_pkg; acts on commands from spsc_ctrl.
module spsc_dp #(
	parameter int MAX_VALUES = spsc_pkg::MAX_VALUES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ball_count_we,
	input  logic [spsc_pkg::VAL_W-1:0] ball_count_wdata,
	input  logic [spsc_pkg::VAL_W-1:0] in_value,
	input  spsc_pkg::cmd_t             cmd,
	output spsc_pkg::stat_t            stat,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_failed,
	output logic                      out_done
);
	import spsc_pkg::*;

	localparam int ADDR_W  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int DEPTH_W = $clog2(MAX_VALUES + 1);
	localparam logic [VAL_W-1:0] MAX_CLIP = VAL_W'(MAX_VALUES);

	logic [VAL_W-1:0]   mem [MAX_VALUES];
	logic [VAL_W-1:0]   rd_q;
	logic [VAL_W-1:0]   ball_count_q;
	logic [VAL_W-1:0]   v_q;
	logic [VAL_W-1:0]   high_q;
	logic [VAL_W-1:0]   k_q;
	logic [VAL_W-1:0]   items_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               latch_q;
	logic               pop_q;
	logic               out_valid_q;
	logic               failed_q;
	logic               done_q;

	logic [VAL_W-1:0]   n_eff;
	logic [VAL_W-1:0]   items_inc;
	logic [DEPTH_W-1:0] depth_m1;
	logic               room;
	logic               fail_now;
	logic               done_now;

	always_comb begin
		if (ball_count_q == '0) begin
			n_eff = VAL_W'(1);
		end else if (32'(ball_count_q) > MAX_VALUES) begin
			n_eff = MAX_CLIP;
		end else begin
			n_eff = ball_count_q;
		end
	end

	assign depth_m1  = depth_q - 1'b1;
	assign room      = 32'(depth_q) < MAX_VALUES;
	assign items_inc = items_q + 1'b1;
	assign done_now  = items_inc >= n_eff;
	assign fail_now  = latch_q | (pop_q & (rd_q != v_q));

	assign stat.latch     = latch_q;
	assign stat.bad       = (v_q == '0) || (v_q > n_eff);
	assign stat.above     = v_q > high_q;
	assign stat.need_push = ({1'b0, high_q} + 1'b1) < {1'b0, v_q};
	assign stat.empty     = depth_q == '0;
	assign stat.push_last = ({1'b0, k_q} + 1'b1) == {1'b0, v_q};
	assign stat.out_free  = !out_valid_q || out_ready;

	// Stack storage, one write or one read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.push && room) begin
			mem[depth_q[ADDR_W-1:0]] <= k_q;
		end
		if (cmd.pop) begin
			rd_q <= mem[depth_m1[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			v_q <= in_value;
		end
		if (cmd.load_k) begin
			k_q <= high_q + 1'b1;
		end else if (cmd.push) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.fin) begin
			failed_q <= fail_now;
			done_q   <= done_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_count_q <= BALL_COUNT_RST;
			high_q       <= '0;
			items_q      <= '0;
			depth_q      <= '0;
			latch_q      <= 1'b0;
			pop_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ball_count_we) begin
				ball_count_q <= ball_count_wdata;
			end
			if (cmd.set_fail) begin
				latch_q <= 1'b1;
			end
			if (cmd.set_high) begin
				high_q <= v_q;
			end
			if (cmd.push && room) begin
				depth_q <= depth_q + 1'b1;
			end
			if (cmd.pop) begin
				depth_q <= depth_m1;
				pop_q   <= 1'b1;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
				pop_q       <= 1'b0;
				if (done_now) begin
					high_q  <= '0;
					items_q <= '0;
					depth_q <= '0;
					latch_q <= 1'b0;
				end else begin
					items_q <= items_inc;
					latch_q <= fail_now;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_failed = failed_q;
	assign out_done   = done_q;

endmodule

// ----- rtl/stack_pop_sequence_checker_core.sv -----
// Stack pop sequence checker: decides whether a stream of values is a valid pop
// order of a stack fed 1..n in ascending order. Each item is accepted, evaluated
// and finished, with one push step between for every value that it pushes onto the
// stack, which the single-port stack memory writes one a cycle; pushes total at most
// n-1 over a sequence. A pop reads the memory in the evaluate cycle and compares in
// the finish cycle. The result register frees the input side while a result waits.
// Depends on spsc_pkg, spsc_if, spsc_ctrl, spsc_dp and assert_macros.svh.
`include "assert_macros.svh"

module stack_pop_sequence_checker_core #(
	parameter int MAX_VALUES = spsc_pkg::MAX_VALUES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ball_count_we,
	input  logic [spsc_pkg::VAL_W-1:0] ball_count_wdata,
	spsc_in_if.sink                   in,
	spsc_out_if.source                out
);
	import spsc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	spsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spsc_dp #(
		.MAX_VALUES (MAX_VALUES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ball_count_we    (ball_count_we),
		.ball_count_wdata (ball_count_wdata),
		.in_value         (in.value),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (out.valid),
		.out_ready        (out.ready),
		.out_failed       (out.failed),
		.out_done         (out.sequence_done)
	);

	`ASSERT_IMPL(a_fin_slot_free, cmd.fin, stat.out_free, "result written while slot busy")
	`ASSERT_IMPL(a_pop_not_empty, cmd.pop, !stat.empty, "pop issued on empty stack")
	`ASSERT_NEXT(a_one_item, in.valid && in.ready, !in.ready, "second item taken while busy")
	`ASSERT_NEXT(a_latch_to_out, cmd.fin && stat.latch, out.valid && out.failed,
		"latched failure not reported")

endmodule

// ----- tb/tb_stack_pop_sequence_checker_core.sv -----
// Testbench of stack_pop_sequence_checker_core: directed and random pop orders, valid and broken,
// are checked item by item against an in-bench stack predictor under random backpressure.
// Depends on spsc_pkg, spsc_if and the RTL of the checker core.
module tb_stack_pop_sequence_checker_core;
	timeunit 1ns;
	timeprecision 1ps;
	import spsc_pkg::*;

	localparam int ITEM_TARGET = 1100;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

	typedef struct packed {
		logic failed;
		logic sequence_done;
	} verdict_t;

	logic             clk;
	logic             arst_n;
	logic             ball_count_we;
	logic [VAL_W-1:0] ball_count_wdata;

	spsc_in_if  in_ch ();
	spsc_out_if out_ch ();

	stack_pop_sequence_checker_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.ball_count_we    (ball_count_we),
		.ball_count_wdata (ball_count_wdata),
		.in               (in_ch.sink),
		.out              (out_ch.source)
	);

	// predictor state
	logic [VAL_W-1:0] pend_stack [0:MAX_VALUES_DEF-1];
	logic [VAL_W-1:0] stack_level;
	logic [VAL_W-1:0] seen_max;
	logic [VAL_W-1:0] taken_count;
	logic             fail_sticky;
	logic [VAL_W-1:0] count_reg;

	verdict_t expected_verdicts [$];
	int       pop_order [$];
	int       feed_stack [$];
	int       mismatch_count;
	int       sent_count;
	bit       tx_steady;
	bit       rx_steady;
	int       hold_len;

	function automatic void clear_sequence_state();
		stack_level = '0;
		seen_max    = '0;
		taken_count = '0;
		fail_sticky = 1'b0;
	endfunction

	function automatic verdict_t judge_value(logic [VAL_W-1:0] v);
		int       n;
		int       k;
		bit       ok;
		verdict_t r;
		n = int'(count_reg);
		if (n == 0) n = 1;
		if (n > MAX_VALUES_DEF) n = MAX_VALUES_DEF;
		if (!fail_sticky) begin
			ok = 1'b1;
			if (v == 0 || v > n) begin
				ok = 1'b0;
			end else if (v > seen_max) begin
				for (k = seen_max + 1; k < v; k++) begin
					if (stack_level < MAX_VALUES_DEF) begin
						pend_stack[stack_level] = VAL_W'(k);
						stack_level = stack_level + 1'b1;
					end
				end
				seen_max = v;
			end else if (stack_level == 0) begin
				ok = 1'b0;
			end else begin
				stack_level = stack_level - 1'b1;
				ok = (pend_stack[stack_level] == v);
			end
			if (!ok) fail_sticky = 1'b1;
		end
		taken_count = taken_count + 1'b1;
		r.failed        = fail_sticky;
		r.sequence_done = (taken_count >= n);
		if (r.sequence_done) clear_sequence_state();
		return r;
	endfunction

	// valid pop order of a stack fed 1..n
	function automatic void make_pop_order(int n);
		int nxt;
		pop_order.delete();
		feed_stack.delete();
		nxt = 1;
		while (pop_order.size() < n) begin
			if (nxt <= n && (feed_stack.size() == 0 || $urandom_range(0, 1) == 1)) begin
				feed_stack.push_back(nxt);
				nxt++;
			end else begin
				pop_order.push_back(feed_stack.pop_back());
			end
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("stack_pop_sequence_checker_core verification failed");
		$finish;
	end

	// receiver: random stalls, steady stretches, long hold-off on request
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				stall_left = hold_len;
				hold_len = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= rx_steady || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	initial begin : result_check
		verdict_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result with no item pending: failed %0b, sequence_done %0b",
						out_ch.failed, out_ch.sequence_done);
					mismatch_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (out_ch.failed !== want.failed) begin
						$error("failed: expected %0b, actual %0b", want.failed, out_ch.failed);
						mismatch_count++;
					end
					if (out_ch.sequence_done !== want.sequence_done) begin
						$error("sequence_done: expected %0b, actual %0b",
							want.sequence_done, out_ch.sequence_done);
						mismatch_count++;
					end
				end
			end
		end
	end

	task automatic send_value(logic [VAL_W-1:0] v);
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		do @(posedge clk); while (!in_ch.ready);
		expected_verdicts.push_back(judge_value(v));
		sent_count++;
		if (!tx_steady && $urandom_range(0, 99) < 25) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_pop_order();
		int i;
		for (i = 0; i < pop_order.size(); i++) send_value(VAL_W'(pop_order[i]));
	endtask

	task automatic wait_drain();
		while (expected_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic set_ball_count(logic [VAL_W-1:0] v);
		in_ch.valid <= 1'b0;
		wait_drain();
		repeat (4) @(posedge clk);
		ball_count_we    <= 1'b1;
		ball_count_wdata <= v;
		@(posedge clk);
		ball_count_we <= 1'b0;
		count_reg = v;
	endtask

	// reset count, deepest push (values 1..4095), then lower n mid-sequence
	task automatic test_deep_stack();
		int i;
		send_value(13'd4096);
		for (i = 4095; i >= 4090; i--) send_value(VAL_W'(i));
		set_ball_count(13'd5);
		send_value(13'd4089);
	endtask

	task automatic test_directed_cases();
		set_ball_count(13'd1);
		send_value(13'd1);
		send_value(13'd0);
		send_value(13'd2);
		set_ball_count(13'd3);
		send_value(13'd3); send_value(13'd2); send_value(13'd1);
		send_value(13'd3); send_value(13'd1); send_value(13'd2);
		send_value(13'd2); send_value(13'd2); send_value(13'd3);
		send_value(13'd1); send_value(13'd1); send_value(13'd3);
		set_ball_count(13'd0);
		send_value(13'd1);
		set_ball_count(VALUE_MAX);
		send_value(VALUE_MAX);
		set_ball_count(13'd2);
		send_value(13'd5);
	endtask

	task automatic test_backpressure();
		int i;
		set_ball_count(13'd6);
		tx_steady = 1'b1;
		rx_steady = 1'b0;
		hold_len  = HOLD_CYCLES;
		for (i = 0; i < 10; i++) begin
			make_pop_order(6);
			send_pop_order();
		end
		in_ch.valid <= 1'b0;
		wait_drain();
		repeat (10) @(posedge clk);
		tx_steady = 1'b0;
		for (i = 0; i < 2; i++) begin
			make_pop_order(6);
			send_pop_order();
		end
	endtask

	task automatic test_random_phases();
		int r;
		int n;
		int kind;
		int a;
		int b;
		int tmp;
		int i;
		while (sent_count < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				set_ball_count(13'd0);
				n = 1;
			end else if (r < 6) begin
				set_ball_count(VAL_W'($urandom_range(4097, 8191)));
				repeat ($urandom_range(1, 5)) send_value(VAL_W'($urandom_range(0, 8191)));
				continue;
			end else if (r < 80) begin
				n = $urandom_range(1, 12);
				set_ball_count(VAL_W'(n));
			end else if (r < 97 || sent_count + 300 > ITEM_TARGET) begin
				n = $urandom_range(13, 64);
				set_ball_count(VAL_W'(n));
			end else begin
				n = $urandom_range(200, 300);
				set_ball_count(VAL_W'(n));
			end
			tx_steady = ($urandom_range(0, 7) == 0);
			rx_steady = tx_steady;
			repeat ($urandom_range(2, 6)) begin
				if (sent_count >= ITEM_TARGET) break;
				make_pop_order(n);
				kind = $urandom_range(0, 99);
				if (kind >= 65 && kind < 80 && n >= 2) begin
					a = $urandom_range(0, n - 1);
					b = $urandom_range(0, n - 1);
					tmp = pop_order[a];
					pop_order[a] = pop_order[b];
					pop_order[b] = tmp;
				end else if (kind >= 80 && kind < 88) begin
					pop_order[$urandom_range(0, n - 1)] = $urandom_range(0, n + 1);
				end else if (kind >= 88 && kind < 95) begin
					for (i = 0; i < n; i++) begin
						if ($urandom_range(0, 3) == 0) pop_order[i] = $urandom_range(0, 8191);
						else pop_order[i] = $urandom_range(0, n + 2);
					end
				end else if (kind >= 95) begin
					repeat ($urandom_range(1, n)) void'(pop_order.pop_back());
				end
				send_pop_order();
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		arst_n           = 1'b0;
		ball_count_we    = 1'b0;
		ball_count_wdata = '0;
		in_ch.valid      = 1'b0;
		in_ch.value      = '0;
		mismatch_count   = 0;
		sent_count       = 0;
		tx_steady        = 1'b0;
		rx_steady        = 1'b0;
		hold_len         = 0;
		count_reg        = BALL_COUNT_RST;
		foreach (pend_stack[i]) pend_stack[i] = '0;
		clear_sequence_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_deep_stack();
		test_directed_cases();
		test_backpressure();
		test_random_phases();

		in_ch.valid <= 1'b0;
		wait_drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
			$display("stack_pop_sequence_checker_core verification clean");
		end else begin
			$display("stack_pop_sequence_checker_core verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/spsc_pkg.sv
rtl/spsc_if.sv
rtl/spsc_ctrl.sv
rtl/spsc_dp.sv
rtl/stack_pop_sequence_checker_core.sv
tb/tb_stack_pop_sequence_checker_core.sv
